/* src/pss_pkg.sv */
// Shared types, constants and register indexes of the strobe sequencer.
`default_nettype none

package pss_pkg;

    // Width of the pulse measurement counter
    localparam int WIDTH_BITS = 8;
    localparam logic [WIDTH_BITS-1:0] WidthLimit = {WIDTH_BITS{1'b1}};

    // Reported width field
    localparam int LAST_W = 8;
    localparam int LastMax = (1 << LAST_W) - 1;

    localparam int CNT_W = 16;
    localparam int IDX_W = 3;
    localparam int DATA_W = 16;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] CFG_RADIO_PRESENT  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_WIDTH_THRESH   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_WIDTH_DEADBAND = 3'd2;
    localparam logic [IDX_W-1:0] CFG_STROBE_ON      = 3'd3;
    localparam logic [IDX_W-1:0] CFG_DARK_WAIT      = 3'd4;
    localparam logic [IDX_W-1:0] CFG_CHECK_INTERVAL = 3'd5;

    // Reset values of the registers
    localparam logic [7:0]       RST_WIDTH_THRESH   = 8'd92;
    localparam logic [7:0]       RST_WIDTH_DEADBAND = 8'd4;
    localparam logic [CNT_W-1:0] RST_STROBE_ON      = 16'd3750;
    localparam logic [CNT_W-1:0] RST_DARK_WAIT      = 16'd62500;
    localparam logic [CNT_W-1:0] RST_CHECK_INTERVAL = 16'd3125;

    // Sequencer phases, one-hot
    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_WAIT     = 5'b00010,
        PH_STROBE_A = 5'b00100,
        PH_GAP      = 5'b01000,
        PH_STROBE_B = 5'b10000
    } phase_t;

    // Configuration register set
    typedef struct packed {
        logic             radio_present;
        logic [7:0]       width_threshold;
        logic [7:0]       width_deadband;
        logic [CNT_W-1:0] strobe_on_ticks;
        logic [CNT_W-1:0] dark_wait_ticks;
        logic [CNT_W-1:0] check_interval_ticks;
    } cfg_t;

    // Light drives of one tick
    typedef struct packed {
        logic wing_lights;
        logic strobe_a_drive;
        logic strobe_b_drive;
    } drive_t;

endpackage

`default_nettype wire

/* src/pss_if.sv */
// Handshake channel interfaces: pulse input, result output and configuration writes.
`default_nettype none

interface pss_in_if;
    logic valid;
    logic ready;
    logic pulse_level;

    modport source (output valid, output pulse_level, input ready);
    modport sink   (input valid, input pulse_level, output ready);
endinterface

interface pss_out_if;
    logic       valid;
    logic       ready;
    logic       wing_lights;
    logic       strobe_a_drive;
    logic       strobe_b_drive;
    logic [7:0] last_width;

    modport source (output valid, output wing_lights, output strobe_a_drive,
                    output strobe_b_drive, output last_width, input ready);
    modport sink   (input valid, input wing_lights, input strobe_a_drive,
                    input strobe_b_drive, input last_width, output ready);
endinterface

interface pss_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/pss_width_meter.sv */
// High-pulse width measurement with saturating tick counter.
`default_nettype none

module pss_width_meter
    import pss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  pulse_level,
    output      logic [WIDTH_BITS-1:0] width_next
);

    logic [WIDTH_BITS-1:0] high_counter_reg, high_counter_next;
    logic [WIDTH_BITS-1:0] width_reg;
    logic                  prev_level_reg;

    // Count high ticks; restart on a rising edge, capture on a falling edge
    always_comb
    begin
        high_counter_next = high_counter_reg;
        width_next        = width_reg;
        if (pulse_level && !prev_level_reg)
        begin
            high_counter_next = WIDTH_BITS'(1);
        end
        else if (pulse_level)
        begin
            if (high_counter_reg < WidthLimit)
            begin
                high_counter_next = high_counter_reg + WIDTH_BITS'(1);
            end
        end
        else if (prev_level_reg)
        begin
            width_next = high_counter_reg;
        end
    end

    // Hold measurement state between accepted items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_counter_reg <= '0;
            width_reg        <= '0;
            prev_level_reg   <= 1'b0;
        end
        else if (en)
        begin
            high_counter_reg <= high_counter_next;
            width_reg        <= width_next;
            prev_level_reg   <= pulse_level;
        end
    end

endmodule

`default_nettype wire

/* src/pss_sequencer.sv */
// Light request hysteresis and the dark wait / strobe phase sequencer.
`default_nettype none

module pss_sequencer
    import pss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire cfg_t                  cfg,
    input  wire logic [WIDTH_BITS-1:0] width,
    output      drive_t                drive_next
);

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] phase_cnt_reg, phase_cnt_next;
    logic [CNT_W-1:0] check_cnt_reg, check_cnt_next;
    logic             request_reg, request_next;
    logic             active_reg, active_next;

    // Advance the phase, then re-evaluate the request whenever idle
    always_comb
    begin
        logic [CNT_W-1:0] pc_inc;
        logic [CNT_W-1:0] cc_inc;
        logic [CNT_W-1:0] len;
        logic             check_due;
        logic             abort;
        logic             done;
        logic [8:0]       on_level;

        pc_inc    = phase_cnt_reg + CNT_W'(1);
        cc_inc    = check_cnt_reg + CNT_W'(1);
        check_due = (cfg.check_interval_ticks == '0) || (cc_inc >= cfg.check_interval_ticks);
        abort     = check_due && cfg.radio_present
                    && (32'(width) < 32'(cfg.width_threshold));
        on_level  = {1'b0, cfg.width_threshold} + {1'b0, cfg.width_deadband};

        unique case (phase_reg)
            PH_WAIT:  len = cfg.dark_wait_ticks;
            default:  len = cfg.strobe_on_ticks;
        endcase
        done = (len == '0) || (pc_inc >= len);

        phase_next     = phase_reg;
        phase_cnt_next = phase_cnt_reg;
        check_cnt_next = check_cnt_reg;
        request_next   = request_reg;
        active_next    = active_reg;

        unique case (phase_reg)
            PH_WAIT:
            begin
                check_cnt_next = check_due ? '0 : cc_inc;
                if (abort)
                begin
                    phase_next     = PH_IDLE;
                    phase_cnt_next = '0;
                end
                else
                begin
                    phase_cnt_next = done ? '0 : pc_inc;
                    if (done)
                        phase_next = PH_STROBE_A;
                end
            end
            PH_STROBE_A:
            begin
                phase_cnt_next = done ? '0 : pc_inc;
                if (done)
                    phase_next = PH_GAP;
            end
            PH_GAP:
            begin
                phase_cnt_next = done ? '0 : pc_inc;
                if (done)
                    phase_next = PH_STROBE_B;
            end
            PH_STROBE_B:
            begin
                phase_cnt_next = done ? '0 : pc_inc;
                if (done)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (phase_next == PH_IDLE)
        begin
            // Inside the hysteresis band the request keeps its value
            priority if (!cfg.radio_present)
                request_next = 1'b1;
            else if (32'(width) >= 32'(on_level))
                request_next = 1'b1;
            else if (32'(width) < 32'(cfg.width_threshold))
                request_next = 1'b0;
            else
                request_next = request_reg;
            active_next = request_next;
            if (request_next)
            begin
                phase_next     = PH_WAIT;
                phase_cnt_next = '0;
                check_cnt_next = '0;
            end
        end

        drive_next.wing_lights    = active_next;
        drive_next.strobe_a_drive = (phase_next == PH_STROBE_A);
        drive_next.strobe_b_drive = (phase_next == PH_STROBE_B);
    end

    // Hold sequencer state between accepted items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            phase_cnt_reg <= '0;
            check_cnt_reg <= '0;
            request_reg   <= 1'b0;
            active_reg    <= 1'b0;
        end
        else if (en)
        begin
            phase_reg     <= phase_next;
            phase_cnt_reg <= phase_cnt_next;
            check_cnt_reg <= check_cnt_next;
            request_reg   <= request_next;
            active_reg    <= active_next;
        end
    end

    // A running sequence always has the lights active
    a_phase_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> active_reg)
        else $error("sequencer out of idle with lights inactive");

    // A new dark wait starts from cleared counters
    a_wait_starts_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (en && (phase_reg != PH_WAIT) && (phase_next == PH_WAIT))
        |=> (phase_cnt_reg == '0) && (check_cnt_reg == '0))
        else $error("dark wait started with stale counters");

    // Strobe A leads only to itself or to the gap
    a_strobe_a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (en && (phase_reg == PH_STROBE_A))
        |=> ((phase_reg == PH_STROBE_A) || (phase_reg == PH_GAP)))
        else $error("strobe A left to an illegal phase");

endmodule

`default_nettype wire

/* src/pwm_switched_strobe_sequencer.sv */
// Top level of the pulse-switched wing light and strobe sequencer.
//
// One input item is one timer tick carrying the sampled control pulse level;
// each accepted item yields exactly one result item with the light drives and
// the last measured pulse width. An item is taken every clock cycle while the
// result register is empty or being emptied: all the per-tick work (width
// counter, hysteresis compare, phase and check counters) settles in one cycle
// between the state and result registers, so a result is valid in the cycle
// after its item is accepted, at one item per cycle while results are taken.
// Configuration writes are always ready and take effect at the next tick.
`default_nettype none

module pwm_switched_strobe_sequencer
    import pss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pss_in_if.sink    pulse_in,
    pss_out_if.source result_out,
    pss_cfg_if.sink   cfg_in
);

    cfg_t                  cfg_reg;
    logic                  out_valid_reg;
    drive_t                drive_reg;
    logic [LAST_W-1:0]     last_width_reg;
    logic                  accept;
    logic [WIDTH_BITS-1:0] width_next;
    drive_t                drive_next;
    logic [LAST_W-1:0]     last_width_next;

    // Take a new item whenever the result register is free or draining
    assign pulse_in.ready = !out_valid_reg || result_out.ready;
    assign accept         = pulse_in.valid && pulse_in.ready;
    assign cfg_in.ready   = 1'b1;

    // Register writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radio_present        <= 1'b0;
            cfg_reg.width_threshold      <= RST_WIDTH_THRESH;
            cfg_reg.width_deadband       <= RST_WIDTH_DEADBAND;
            cfg_reg.strobe_on_ticks      <= RST_STROBE_ON;
            cfg_reg.dark_wait_ticks      <= RST_DARK_WAIT;
            cfg_reg.check_interval_ticks <= RST_CHECK_INTERVAL;
        end
        else if (cfg_in.valid)
        begin
            unique case (cfg_in.index)
                CFG_RADIO_PRESENT:  cfg_reg.radio_present        <= cfg_in.data[0];
                CFG_WIDTH_THRESH:   cfg_reg.width_threshold      <= cfg_in.data[7:0];
                CFG_WIDTH_DEADBAND: cfg_reg.width_deadband       <= cfg_in.data[7:0];
                CFG_STROBE_ON:      cfg_reg.strobe_on_ticks      <= cfg_in.data;
                CFG_DARK_WAIT:      cfg_reg.dark_wait_ticks      <= cfg_in.data;
                CFG_CHECK_INTERVAL: cfg_reg.check_interval_ticks <= cfg_in.data;
                default:            ;
            endcase
        end
    end

    pss_width_meter u_meter (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (accept),
        .pulse_level (pulse_in.pulse_level),
        .width_next  (width_next)
    );

    pss_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (accept),
        .cfg        (cfg_reg),
        .width      (width_next),
        .drive_next (drive_next)
    );

    // Saturate the reported width to the output field
    always_comb
    begin
        if (32'(width_next) > LastMax)
            last_width_next = LAST_W'(LastMax);
        else
            last_width_next = LAST_W'(width_next);
    end

    // Result register: load on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_reg      <= drive_next;
            last_width_reg <= last_width_next;
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.wing_lights    = drive_reg.wing_lights;
    assign result_out.strobe_a_drive = drive_reg.strobe_a_drive;
    assign result_out.strobe_b_drive = drive_reg.strobe_b_drive;
    assign result_out.last_width     = last_width_reg;

    // Every accepted item leaves a result waiting in the next cycle
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_out.valid)
        else $error("accepted item produced no result");

endmodule

`default_nettype wire
